// File: src/ffha_pkg.sv
// Shared types and codes for the first-fit heap allocator.
// No dependencies; imported by the allocator top level, the checker and the testbench.
`default_nettype none
package ffha_pkg;

    localparam int AW = 23;
    localparam logic [AW-1:0] MASK23 = 23'h7FFFFF;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_SIZE  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_OUT_OF_HEAP = 3'd1,
        ST_TABLE_FULL  = 3'd2,
        ST_NO_BLOCK    = 3'd3,
        ST_NULL        = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_CHECK,
        S_SPLIT_A,
        S_SPLIT_B,
        S_NFETCH,
        S_NCHECK,
        S_PMERGE,
        S_GROW,
        S_ROUND,
        S_APPEND,
        S_LINK
    } state_t;

endpackage
`default_nettype wire

// File: src/ffha_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module ffha_ram #(
    parameter int WIDTH = 54,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: src/first_fit_heap_allocator.sv
// First-fit heap allocator with split and coalesce over an address-ordered block table.
// Depends on ffha_pkg and ffha_ram.
//
// Usage:
//   Request words enter on s_tvalid/s_tready. s_tuser[1:0] is the operation
//   (allocate, free, size query); s_tdata carries request_bytes and
//   payload_offset. One response word leaves on m_tvalid/m_tready with the
//   status in m_tuser and result_offset / block_bytes in m_tdata.
//   cfg_wr_en with cfg_wr_data writes heap_limit; write it only while idle.
// Sequence:
//   One request at a time. The block list is walked one entry at a time
//   (registered table read in S_FETCH, then compare in S_CHECK) until an entry
//   decides the request. A split then writes the tail (S_SPLIT_A) and the head
//   (S_SPLIT_B); a free checks a successor (S_NFETCH, S_NCHECK) and merges with
//   the predecessor in S_PMERGE; an append computes the new end (S_GROW), rounds
//   it up to a page (S_ROUND), writes the entry (S_APPEND) and, when the list is
//   not empty, links it (S_LINK). Null, unknown operations and offsets on an empty
//   list answer in the cycle after acceptance. PAGE_BYTES must be a power of two.
// Reset:
//   The heap is empty, heap_limit is 4 MiB; table contents need no clearing.
// Stall:
//   A response held by m_tready keeps s_tready low until it is taken.
`default_nettype none
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 12,
    parameter int PAGE_BYTES   = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [22:0] request_bytes, [45:23] payload_offset
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // [22:0] result_offset, [45:23] block_bytes
    output logic      [2:0]  m_tuser,   // [2:0] status
    input  wire logic        cfg_wr_en,
    input  wire logic [22:0] cfg_wr_data
);

    localparam int IW  = $clog2(MAX_BLOCKS);
    localparam int NW  = AW + 1;              // rounded request size
    localparam int SW  = AW + 3;              // sums of offsets and sizes
    localparam logic [SW-1:0] HDR   = SW'(HEADER_BYTES);
    localparam logic [SW-1:0] PGM1  = SW'(PAGE_BYTES - 1);

    typedef struct packed {
        logic [AW-1:0] start;
        logic [AW-1:0] size;
        logic          free;
        logic          has_next;
        logic [IW-1:0] nxt;
    } entry_t;

    localparam int EW = $bits(entry_t);

    state_t          state_reg, state_next;
    op_t             op_reg, op_next;
    logic [NW-1:0]   need_reg, need_next;
    logic [AW-1:0]   off_reg, off_next;
    logic [IW-1:0]   cur_reg, cur_next;
    entry_t          prv_reg, prv_next;
    logic [IW-1:0]   prv_idx_reg, prv_idx_next;
    logic            prv_valid_reg, prv_valid_next;
    entry_t          b_reg, b_next;
    logic [IW-1:0]   b_idx_reg, b_idx_next;
    logic [IW-1:0]   new_slot_reg, new_slot_next;
    logic [MAX_BLOCKS-1:0] slot_reg, slot_next;
    logic            first_valid_reg, first_valid_next;
    logic [IW-1:0]   first_reg, first_next;
    logic [AW-1:0]   heap_top_reg, heap_top_next;
    logic [AW-1:0]   limit_reg;
    logic [SW-1:0]   new_end_reg, new_end_next;
    logic [SW-1:0]   rounded_reg, rounded_next;
    logic            out_valid_reg, out_valid_next;
    status_t         out_status_reg, out_status_next;
    logic [AW-1:0]   out_off_reg, out_off_next;
    logic [AW-1:0]   out_bytes_reg, out_bytes_next;

    logic            ram_we;
    logic [IW-1:0]   ram_waddr, ram_raddr;
    entry_t          ram_wdata, ram_rdata;
    logic [EW-1:0]   ram_rbits;

    logic [MAX_BLOCKS-1:0] vacant, vacant_low;
    logic [IW-1:0]   vacant_idx;
    logic            vacant_any;

    logic            accept;
    logic [AW-1:0]   in_req, in_off;
    logic [NW-1:0]   in_need;

    ffha_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    assign ram_rdata = entry_t'(ram_rbits);

    // lowest vacant slot: isolate the lowest set bit, then encode it
    always_comb
    begin
        vacant     = ~slot_reg;
        vacant_low = vacant & (~vacant + MAX_BLOCKS'(1));
        vacant_any = |vacant;
        vacant_idx = '0;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            if (vacant_low[i])
            begin
                vacant_idx = vacant_idx | IW'(i);
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign in_req   = s_tdata[22:0];
    assign in_off   = s_tdata[45:23];
    assign in_need  = ({1'b0, in_req} + NW'(7)) & ~NW'(7);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_bytes_reg, out_off_reg};

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        need_next        = need_reg;
        off_next         = off_reg;
        cur_next         = cur_reg;
        prv_next         = prv_reg;
        prv_idx_next     = prv_idx_reg;
        prv_valid_next   = prv_valid_reg;
        b_next           = b_reg;
        b_idx_next       = b_idx_reg;
        new_slot_next    = new_slot_reg;
        slot_next        = slot_reg;
        first_valid_next = first_valid_reg;
        first_next       = first_reg;
        heap_top_next    = heap_top_reg;
        new_end_next     = new_end_reg;
        rounded_next     = rounded_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_off_next     = out_off_reg;
        out_bytes_next   = out_bytes_reg;
        ram_we           = 1'b0;
        ram_waddr        = cur_reg;
        ram_wdata        = b_reg;
        ram_raddr        = cur_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = op_t'(s_tuser);
                    need_next       = in_need;
                    off_next        = in_off;
                    cur_next        = first_reg;
                    prv_valid_next  = 1'b0;
                    out_status_next = ST_OK;
                    out_off_next    = '0;
                    out_bytes_next  = '0;
                    unique case (op_t'(s_tuser))
                        OP_ALLOC:
                        begin
                            state_next = first_valid_reg ? S_FETCH : S_GROW;
                        end
                        OP_FREE, OP_SIZE:
                        begin
                            if (in_off == '0)
                            begin
                                out_status_next = ST_NULL;
                                out_valid_next  = 1'b1;
                            end
                            else if (!first_valid_reg)
                            begin
                                out_status_next = ST_NO_BLOCK;
                                out_valid_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            out_status_next = ST_NO_BLOCK;
                            out_valid_next  = 1'b1;
                        end
                    endcase
                end
            end

            S_FETCH:
            begin
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (ram_rdata.free && ({1'b0, ram_rdata.size} >= need_reg))
                    begin
                        b_next     = ram_rdata;
                        b_idx_next = cur_reg;
                        if ((SW'(ram_rdata.size) > SW'(need_reg) + HDR + SW'(8)) && vacant_any)
                        begin
                            new_slot_next = vacant_idx;
                            state_next    = S_SPLIT_A;
                        end
                        else
                        begin
                            // hand the block out whole
                            ram_we          = 1'b1;
                            ram_waddr       = cur_reg;
                            ram_wdata       = ram_rdata;
                            ram_wdata.free  = 1'b0;
                            out_off_next    = AW'(SW'(ram_rdata.start) + HDR);
                            out_bytes_next  = ram_rdata.size;
                            out_valid_next  = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                    else
                    begin
                        prv_next       = ram_rdata;
                        prv_idx_next   = cur_reg;
                        prv_valid_next = 1'b1;
                        cur_next       = ram_rdata.nxt;
                        state_next     = ram_rdata.has_next ? S_FETCH : S_GROW;
                    end
                end
                else if (SW'(ram_rdata.start) + HDR == SW'(off_reg))
                begin
                    if (op_reg == OP_SIZE)
                    begin
                        out_bytes_next = ram_rdata.size;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        b_next      = ram_rdata;
                        b_next.free = 1'b1;
                        b_idx_next  = cur_reg;
                        cur_next    = ram_rdata.nxt;
                        state_next  = ram_rdata.has_next ? S_NFETCH : S_PMERGE;
                    end
                end
                else
                begin
                    prv_next       = ram_rdata;
                    prv_idx_next   = cur_reg;
                    prv_valid_next = 1'b1;
                    cur_next       = ram_rdata.nxt;
                    if (ram_rdata.has_next)
                    begin
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        out_status_next = ST_NO_BLOCK;
                        out_valid_next  = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end

            S_SPLIT_A:
            begin
                // tail of the split block becomes a new free block
                ram_we             = 1'b1;
                ram_waddr          = new_slot_reg;
                ram_wdata.start    = AW'(SW'(b_reg.start) + HDR + SW'(need_reg));
                ram_wdata.size     = AW'(SW'(b_reg.size) - SW'(need_reg) - HDR);
                ram_wdata.free     = 1'b1;
                ram_wdata.has_next = b_reg.has_next;
                ram_wdata.nxt      = b_reg.nxt;
                slot_next[new_slot_reg] = 1'b1;
                state_next         = S_SPLIT_B;
            end

            S_SPLIT_B:
            begin
                ram_we             = 1'b1;
                ram_waddr          = b_idx_reg;
                ram_wdata          = b_reg;
                ram_wdata.free     = 1'b0;
                ram_wdata.size     = need_reg[AW-1:0];
                ram_wdata.has_next = 1'b1;
                ram_wdata.nxt      = new_slot_reg;
                out_off_next       = AW'(SW'(b_reg.start) + HDR);
                out_bytes_next     = need_reg[AW-1:0];
                out_valid_next     = 1'b1;
                state_next         = S_IDLE;
            end

            S_NFETCH:
            begin
                state_next = S_NCHECK;
            end

            S_NCHECK:
            begin
                // absorb a contiguous free successor
                if (ram_rdata.free &&
                    (SW'(b_reg.start) + HDR + SW'(b_reg.size) == SW'(ram_rdata.start)))
                begin
                    b_next.size     = AW'(SW'(b_reg.size) + HDR + SW'(ram_rdata.size));
                    b_next.has_next = ram_rdata.has_next;
                    b_next.nxt      = ram_rdata.nxt;
                    slot_next[cur_reg] = 1'b0;
                end
                state_next = S_PMERGE;
            end

            S_PMERGE:
            begin
                ram_we = 1'b1;
                if (prv_valid_reg && prv_reg.free &&
                    (SW'(prv_reg.start) + HDR + SW'(prv_reg.size) == SW'(b_reg.start)))
                begin
                    ram_waddr          = prv_idx_reg;
                    ram_wdata          = prv_reg;
                    ram_wdata.size     = AW'(SW'(prv_reg.size) + HDR + SW'(b_reg.size));
                    ram_wdata.has_next = b_reg.has_next;
                    ram_wdata.nxt      = b_reg.nxt;
                    slot_next[b_idx_reg] = 1'b0;
                end
                else
                begin
                    ram_waddr = b_idx_reg;
                    ram_wdata = b_reg;
                end
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end

            S_GROW:
            begin
                new_end_next = SW'(heap_top_reg) + SW'(need_reg) + HDR;
                state_next   = S_ROUND;
            end

            S_ROUND:
            begin
                // round the new end up to a whole page
                rounded_next = (new_end_reg + PGM1) & ~PGM1;
                state_next   = S_APPEND;
            end

            S_APPEND:
            begin
                state_next = S_IDLE;
                if ((new_end_reg > SW'(limit_reg)) || (rounded_reg > SW'(MASK23)))
                begin
                    out_status_next = ST_OUT_OF_HEAP;
                    out_valid_next  = 1'b1;
                end
                else if (!vacant_any)
                begin
                    out_status_next = ST_TABLE_FULL;
                    out_valid_next  = 1'b1;
                end
                else
                begin
                    ram_we             = 1'b1;
                    ram_waddr          = vacant_idx;
                    ram_wdata.start    = heap_top_reg;
                    ram_wdata.size     = need_reg[AW-1:0];
                    ram_wdata.free     = 1'b0;
                    ram_wdata.has_next = 1'b0;
                    ram_wdata.nxt      = '0;
                    slot_next[vacant_idx] = 1'b1;
                    new_slot_next      = vacant_idx;
                    out_off_next       = AW'(SW'(heap_top_reg) + HDR);
                    out_bytes_next     = need_reg[AW-1:0];
                    heap_top_next      = rounded_reg[AW-1:0];
                    if (prv_valid_reg)
                    begin
                        state_next = S_LINK;
                    end
                    else
                    begin
                        first_valid_next = 1'b1;
                        first_next       = vacant_idx;
                        out_valid_next   = 1'b1;
                    end
                end
            end

            S_LINK:
            begin
                ram_we             = 1'b1;
                ram_waddr          = prv_idx_reg;
                ram_wdata          = prv_reg;
                ram_wdata.has_next = 1'b1;
                ram_wdata.nxt      = new_slot_reg;
                out_valid_next     = 1'b1;
                state_next         = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            slot_reg        <= '0;
            first_valid_reg <= 1'b0;
            first_reg       <= '0;
            heap_top_reg    <= '0;
            limit_reg       <= 23'd4194304;
            out_valid_reg   <= 1'b0;
            prv_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            slot_reg        <= slot_next;
            first_valid_reg <= first_valid_next;
            first_reg       <= first_next;
            heap_top_reg    <= heap_top_next;
            out_valid_reg   <= out_valid_next;
            prv_valid_reg   <= prv_valid_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        need_reg       <= need_next;
        off_reg        <= off_next;
        cur_reg        <= cur_next;
        prv_reg        <= prv_next;
        prv_idx_reg    <= prv_idx_next;
        b_reg          <= b_next;
        b_idx_reg      <= b_idx_next;
        new_slot_reg   <= new_slot_next;
        new_end_reg    <= new_end_next;
        rounded_reg    <= rounded_next;
        out_status_reg <= out_status_next;
        out_off_reg    <= out_off_next;
        out_bytes_reg  <= out_bytes_next;
    end

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("table written while idle");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ((state_reg != S_IDLE) || out_valid_reg))
        else $error("accepted word neither worked on nor answered");

    a_list_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (first_valid_reg == (slot_reg != '0)))
        else $error("list head and slot map disagree");

endmodule
`default_nettype wire

// File: sim/ffha_checker.sv
// Checker for the first-fit heap allocator: watches both stream channels and the
// heap_limit write port, predicts each response and compares it. Depends on ffha_pkg.
`default_nettype none
module ffha_checker
    import ffha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,   // [22:0] request_bytes, [45:23] payload_offset
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,   // [22:0] result_offset, [45:23] block_bytes
    input  wire logic [2:0]  m_tuser,   // [2:0] status
    input  wire logic        cfg_wr_en,
    input  wire logic [22:0] cfg_wr_data,
    output int               errors,
    output int               pending
);

    localparam int NBLK = 64;
    localparam int HDR  = 12;
    localparam int PAGE = 4096;

    typedef struct packed {
        status_t        st;
        logic [AW-1:0]  roff;
        logic [AW-1:0]  bytes;
    } answer_t;

    answer_t     answers_due[$];

    int unsigned blk_start [NBLK];
    int unsigned blk_size  [NBLK];
    bit          blk_free  [NBLK];
    bit          blk_hasnx [NBLK];
    int          blk_nx    [NBLK];
    bit          slot_used [NBLK];
    bit          head_ok;
    int          head;
    int unsigned top;
    int unsigned limit;

    initial errors = 0;
    assign pending = answers_due.size();

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        $display("tb: mismatch %s got %0d want %0d", what, got, want);
        errors++;
    endtask

    function automatic int take_slot();
        for (int i = 0; i < NBLK; i++)
        begin
            if (!slot_used[i])
            begin
                slot_used[i] = 1'b1;
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int locate(input int unsigned off, output int pred);
        int cur;
        int p;
        cur = head_ok ? head : -1;
        p = -1;
        for (int n = 0; n < NBLK && cur >= 0; n++)
        begin
            if (blk_start[cur] + HDR == off)
            begin
                pred = p;
                return cur;
            end
            p = cur;
            cur = blk_hasnx[cur] ? blk_nx[cur] : -1;
        end
        pred = -1;
        return -1;
    endfunction

    function automatic answer_t allocate(input int unsigned req);
        answer_t     a;
        int unsigned need;
        int unsigned new_end;
        int unsigned rounded;
        int          cur;
        int          last;
        int          s;
        a = '{ST_OK, '0, '0};
        need = (req + 7) & ~32'd7;
        cur = head_ok ? head : -1;
        last = -1;
        for (int n = 0; n < NBLK && cur >= 0; n++)
        begin
            if (blk_free[cur] && blk_size[cur] >= need)
            begin
                blk_free[cur] = 1'b0;
                if (blk_size[cur] > need + HDR + 8)
                begin
                    s = take_slot();
                    if (s >= 0)
                    begin
                        blk_start[s] = blk_start[cur] + HDR + need;
                        blk_size[s]  = blk_size[cur] - need - HDR;
                        blk_free[s]  = 1'b1;
                        blk_hasnx[s] = blk_hasnx[cur];
                        blk_nx[s]    = blk_nx[cur];
                        blk_size[cur]  = need;
                        blk_hasnx[cur] = 1'b1;
                        blk_nx[cur]    = s;
                    end
                end
                a.roff  = AW'(blk_start[cur] + HDR);
                a.bytes = AW'(blk_size[cur]);
                return a;
            end
            last = cur;
            cur = blk_hasnx[cur] ? blk_nx[cur] : -1;
        end
        new_end = top + need + HDR;
        rounded = ((new_end + PAGE - 1) / PAGE) * PAGE;
        if (new_end > limit || rounded > 32'h7FFFFF)
        begin
            a.st = ST_OUT_OF_HEAP;
            return a;
        end
        s = take_slot();
        if (s < 0)
        begin
            a.st = ST_TABLE_FULL;
            return a;
        end
        blk_start[s] = top;
        blk_size[s]  = need;
        blk_free[s]  = 1'b0;
        blk_hasnx[s] = 1'b0;
        blk_nx[s]    = 0;
        if (last >= 0)
        begin
            blk_hasnx[last] = 1'b1;
            blk_nx[last]    = s;
        end
        else
        begin
            head_ok = 1'b1;
            head    = s;
        end
        a.roff  = AW'(top + HDR);
        a.bytes = AW'(need);
        top = rounded;
        return a;
    endfunction

    function automatic answer_t release_block(input int unsigned off);
        answer_t a;
        int      pred;
        int      b;
        int      nb;
        a = '{ST_OK, '0, '0};
        if (off == 0)
        begin
            a.st = ST_NULL;
            return a;
        end
        b = locate(off, pred);
        if (b < 0)
        begin
            a.st = ST_NO_BLOCK;
            return a;
        end
        blk_free[b] = 1'b1;
        if (blk_hasnx[b])
        begin
            nb = blk_nx[b];
            if (blk_free[nb] && blk_start[b] + HDR + blk_size[b] == blk_start[nb])
            begin
                blk_size[b]  += HDR + blk_size[nb];
                blk_hasnx[b]  = blk_hasnx[nb];
                blk_nx[b]     = blk_nx[nb];
                slot_used[nb] = 1'b0;
            end
        end
        if (pred >= 0)
        begin
            if (blk_free[pred] && blk_start[pred] + HDR + blk_size[pred] == blk_start[b])
            begin
                blk_size[pred] += HDR + blk_size[b];
                blk_hasnx[pred] = blk_hasnx[b];
                blk_nx[pred]    = blk_nx[b];
                slot_used[b]    = 1'b0;
            end
        end
        return a;
    endfunction

    function automatic answer_t query(input int unsigned off);
        answer_t a;
        int      pred;
        int      b;
        a = '{ST_OK, '0, '0};
        if (off == 0)
        begin
            a.st = ST_NULL;
            return a;
        end
        b = locate(off, pred);
        if (b < 0)
            a.st = ST_NO_BLOCK;
        else
            a.bytes = AW'(blk_size[b]);
        return a;
    endfunction

    // Sample at the falling edge: a handshake seen here completes at the next rising edge.
    always @(negedge clk)
    begin
        answer_t want;
        answer_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < NBLK; i++)
                slot_used[i] = 1'b0;
            head_ok = 1'b0;
            head    = 0;
            top     = 0;
            limit   = 4194304;
            answers_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{status_t'(m_tuser), m_tdata[22:0], m_tdata[45:23]};
                if (answers_due.size() == 0)
                    report("unexpected response status", m_tuser, 0);
                else
                begin
                    want = answers_due.pop_front();
                    if (got.st != want.st)
                        report("status", got.st, want.st);
                    if (got.roff != want.roff)
                        report("result_offset", got.roff, want.roff);
                    if (got.bytes != want.bytes)
                        report("block_bytes", got.bytes, want.bytes);
                end
            end
            if (s_tvalid && s_tready)
            begin
                case (op_t'(s_tuser))
                    OP_ALLOC: want = allocate(s_tdata[22:0]);
                    OP_FREE:  want = release_block(s_tdata[45:23]);
                    OP_SIZE:  want = query(s_tdata[45:23]);
                    default:  want = '{ST_NO_BLOCK, '0, '0};
                endcase
                answers_due.push_back(want);
            end
            if (cfg_wr_en)
                limit = cfg_wr_data;
        end
    end

endmodule
`default_nettype wire

// File: sim/tb.sv
// Testbench top for the first-fit heap allocator: reset, request stimulus, response
// back-pressure, heap_limit phases and verdict. Uses ffha_pkg, ffha_checker and the allocator.
`default_nettype none
module tb
    import ffha_pkg::*;
();

    localparam int CYCLE_LIMIT = 3000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [22:0] cfg_wr_data = '0;
    int          errors;
    int          pending;

    int          words_in = 0;
    int          words_out = 0;
    int          st_seen [5];
    int          cycles = 0;
    int          burst_left = 0;
    int          rdy_left = 0;
    int          rdy_mode = 0;
    logic [22:0] live_offs[$];
    logic [22:0] dead_offs[$];

    always #6 clk = ~clk;

    first_fit_heap_allocator i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    ffha_checker i_chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .errors(errors), .pending(pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: switch between always-ready and two stall densities.
    always @(posedge clk)
    begin
        if (rdy_left == 0)
        begin
            rdy_mode = $urandom_range(0, 2);
            rdy_left = $urandom_range(20, 300);
        end
        rdy_left--;
        case (rdy_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    // Track words and harvest handed-out offsets for later frees and queries.
    always @(negedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            words_in++;
        if (rst_n && m_tvalid && m_tready)
        begin
            words_out++;
            if (m_tuser < 5)
                st_seen[m_tuser]++;
            if (m_tuser == ST_OK && m_tdata[22:0] != 0)
                live_offs.push_back(m_tdata[22:0]);
        end
    end

    task automatic send_word(input op_t op, input logic [22:0] req, input logic [22:0] off);
        bit taken;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, off, req};
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic drain();
        // drop valid so a held word is not taken again
        s_tvalid <= 1'b0;
        while (words_out != words_in)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_limit(input logic [22:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [22:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return 23'($urandom_range(0, 256));
        else if (r < 96)
            return 23'($urandom_range(0, 8192));
        return 23'($urandom_range(0, 23'h7FFFFF));
    endfunction

    task automatic random_words(input int count);
        int          r;
        int          k;
        logic [22:0] off;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_word(OP_ALLOC, pick_size(), 23'($urandom_range(0, 23'h7FFFFF)));
            else if (r < 80 && live_offs.size() > 0)
            begin
                k = $urandom_range(0, live_offs.size() - 1);
                off = live_offs[k];
                live_offs.delete(k);
                dead_offs.push_back(off);
                send_word(OP_FREE, 23'($urandom_range(0, 23'h7FFFFF)), off);
            end
            else if (r < 92 && live_offs.size() > 0)
                send_word(OP_SIZE, 23'($urandom_range(0, 23'h7FFFFF)),
                          live_offs[$urandom_range(0, live_offs.size() - 1)]);
            else if (r < 95 && dead_offs.size() > 0)
                // revisit an old offset: double free or query of a merged block
                send_word(op_t'($urandom_range(OP_FREE, OP_SIZE)), 23'd0,
                          dead_offs[$urandom_range(0, dead_offs.size() - 1)]);
            else
            begin
                case ($urandom_range(0, 3))
                    0: off = 23'd0;
                    1: off = 23'($urandom_range(0, 23'h7FFFFF));
                    default: off = 23'($urandom_range(1, 40000));
                endcase
                send_word(op_t'($urandom_range(OP_FREE, OP_NONE)),
                          23'($urandom_range(0, 23'h7FFFFF)), off);
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_limit(23'd4194304);

        // Directed: appends, null and unknown offsets, double free, reuse, split, growth limit.
        send_word(OP_ALLOC, 23'd0, 23'd0);
        send_word(OP_ALLOC, 23'd1, 23'd0);
        send_word(OP_ALLOC, 23'd200, 23'd0);
        send_word(OP_FREE, 23'd0, 23'd0);
        send_word(OP_SIZE, 23'd0, 23'd0);
        send_word(OP_NONE, 23'h7FFFFF, 23'h7FFFFF);
        send_word(OP_SIZE, 23'd0, 23'd5);
        send_word(OP_SIZE, 23'd0, 23'd12);
        send_word(OP_FREE, 23'd0, 23'd4108);
        send_word(OP_FREE, 23'd0, 23'd4108);
        send_word(OP_SIZE, 23'd0, 23'd4108);
        send_word(OP_ALLOC, 23'd8, 23'd0);
        send_word(OP_FREE, 23'd0, 23'd8204);
        send_word(OP_ALLOC, 23'd8, 23'd0);
        send_word(OP_SIZE, 23'd0, 23'd8224);
        send_word(OP_ALLOC, 23'd4194304, 23'd0);
        send_word(OP_ALLOC, 23'h7FFFFF, 23'd0);
        send_word(OP_SIZE, 23'd0, 23'h7FFFFF);
        send_word(OP_FREE, 23'd0, 23'd12);
        send_word(OP_FREE, 23'd0, 23'd8204);

        random_words(400);
        set_limit(23'd4096);
        random_words(200);
        set_limit(23'($urandom_range(200000, 4194304)));
        random_words(400);
        set_limit(23'd4194304);
        random_words(300);

        s_tvalid <= 1'b0;
        @(posedge clk);
        drain();
        $display("tb: %0d requests, %0d responses; ok %0d, out of heap %0d, table full %0d,",
                 words_in, words_out, st_seen[0], st_seen[1], st_seen[2]);
        $display("tb: no such block %0d, null %0d, over four heap_limit settings",
                 st_seen[3], st_seen[4]);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
